// ----- hdl/cgge_pkg.sv -----
// ---------------------------------------------------------------------------
// cgge_pkg: shared types and constants
// Fixed-point constants, field widths and register codes for the gate
// gain envelope.
// ---------------------------------------------------------------------------
`default_nettype none

package cgge_pkg;

    localparam int Q15_W  = 16;  // Q1.15 value / Q0.16 coefficient
    localparam int LEN_W  = 13;  // block length field
    localparam int HOLD_W = 18;  // hold counter
    localparam int NUM_W  = 31;  // interpolation dividend
    localparam int MAC_W  = 34;  // multiply-add result

    localparam logic [Q15_W-1:0] UNITY    = 16'd32768;
    localparam logic [Q15_W-1:0] C_FALL   = 16'd19661;  // 0.3 in Q0.16
    localparam logic [Q15_W-1:0] C_RISE   = 16'd6554;   // 0.1 in Q0.16
    localparam logic [Q15_W-1:0] THR_LOW  = 16'd328;    // 0.01 in Q1.15
    localparam logic [Q15_W-1:0] THR_HIGH = 16'd32440;  // 0.99 in Q1.15
    localparam logic [16:0]      ROUND_HALF = 17'd32768;

    // configuration register indexes
    localparam logic [2:0] CFG_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_FLOOR     = 3'd1;
    localparam logic [2:0] CFG_ATTACK    = 3'd2;
    localparam logic [2:0] CFG_RELEASE   = 3'd3;
    localparam logic [2:0] CFG_HOLD      = 3'd4;

    typedef logic signed [16:0]      mac_a_t;
    typedef logic [Q15_W-1:0]        mac_b_t;
    typedef logic [16:0]             mac_add_t;
    typedef logic signed [MAC_W-1:0] mac_res_t;

    function automatic logic [Q15_W-1:0] sat_q15(input logic [Q15_W-1:0] v);
        sat_q15 = (v > UNITY) ? UNITY : v;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/cgge_mac.sv -----
// ---------------------------------------------------------------------------
// cgge_mac: shared multiply-add unit
// Signed 17 x unsigned 16 multiply plus an unsigned rounding/bias term.
// ---------------------------------------------------------------------------
`default_nettype none

module cgge_mac
    import cgge_pkg::*;
(
    input  wire mac_a_t   a,
    input  wire mac_b_t   b,
    input  wire mac_add_t addend,
    output mac_res_t      result
);

    logic signed [16:0] b_s;
    mac_res_t           prod;

    assign b_s    = $signed({1'b0, b});
    assign prod   = a * b_s;
    assign result = prod + $signed({{(MAC_W-17){1'b0}}, addend});

endmodule

`default_nettype wire

// ----- hdl/cgge_div.sv -----
// ---------------------------------------------------------------------------
// cgge_div: iterative restoring divider
// One quotient bit per cycle; quotient assumed to fit in 16 bits.
// ---------------------------------------------------------------------------
`default_nettype none

module cgge_div
    import cgge_pkg::*;
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    start,
    input  wire [NUM_W-1:0]        dividend,
    input  wire [Q15_W-1:0]        divisor,
    output logic                   done,
    output logic [Q15_W-1:0]       quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] n_reg;
    logic [Q15_W-1:0] rem_reg;
    logic [Q15_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [Q15_W:0]   trial;
    logic             ge;
    logic [Q15_W:0]   diff;

    assign trial = {rem_reg, n_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                n_reg    <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                cnt_reg  <= CNT_W'(NUM_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                // remainder always below divisor, so it fits back in 16 bits
                rem_reg <= ge ? diff[Q15_W-1:0] : trial[Q15_W-1:0];
                n_reg   <= {n_reg[NUM_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = n_reg[Q15_W-1:0];

endmodule

`default_nettype wire

// ----- hdl/confidence_gate_gain_envelope.sv -----
// ---------------------------------------------------------------------------
// confidence_gate_gain_envelope: confidence-driven gate gain envelope
// Smooths a per-block confidence, maps it to a desired gain with hold, and
// steps a one-pole attack/release gain filter once per sample of the block until
// the block ends or the gain settles.
// Sequence: smoothing, mapping, divide, hold, up to block_len filter steps,
//   then a clamp into the output register; the divide is skipped when no
//   interpolation is needed.
// Flow: one block at a time; a new input beat is taken only after the last
//   block has been clamped into the output register.
// Reset: config registers and smoothed confidence clear, gain starts at unity.
`default_nettype none

module confidence_gate_gain_envelope
    import cgge_pkg::*;
#(
    parameter int MAX_BLOCK = 4096
)
(
    input  wire         clk,
    input  wire         rst_n,

    // input stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [15:0] confidence, [28:16] block_len, rest zero

    // result stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] gain
    output logic        m_axis_tuser,   // [0] gating

    // register writes
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [17:0] cfg_data
);

    // longest block the filter loop will run; inputs above it saturate
    localparam logic [LEN_W-1:0] LEN_CAP =
        (MAX_BLOCK >= (1 << LEN_W) - 1) ? {LEN_W{1'b1}} : LEN_W'(MAX_BLOCK);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SMOOTH,
        ST_DES,
        ST_DIV,
        ST_HOLD,
        ST_LOOP,
        ST_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic [Q15_W-1:0]  thr_reg;
    logic [Q15_W-1:0]  flr_reg;
    logic [Q15_W-1:0]  atk_reg;
    logic [Q15_W-1:0]  rel_reg;
    logic [HOLD_W-1:0] hold_samples_reg;

    // block state
    logic [Q15_W-1:0]  sm_reg;
    logic [Q15_W-1:0]  gain_reg;
    logic [HOLD_W-1:0] hold_reg;

    // per-item working registers
    logic [Q15_W-1:0]  conf_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [Q15_W-1:0]  des_reg;
    logic [Q15_W-1:0]  target_reg;
    logic [Q15_W-1:0]  coef_reg;
    logic              gating_reg;
    logic [LEN_W-1:0]  cnt_reg;

    // output register
    logic              m_valid_reg;
    logic [Q15_W-1:0]  m_gain_reg;
    logic              m_gating_reg;

    logic [Q15_W-1:0]  thr_sat;
    logic [Q15_W-1:0]  flr_sat;
    logic [LEN_W-1:0]  in_len;
    logic              conf_lt;

    mac_a_t            mac_a;
    mac_b_t            mac_b;
    mac_add_t          mac_add;
    mac_res_t          mac_res;

    logic              div_needed;
    logic              div_start;
    logic              div_done;
    logic [Q15_W-1:0]  div_q;
    logic [Q15_W:0]    interp_sum;

    logic [Q15_W-1:0]  hold_tgt;
    logic [HOLD_W-1:0] hold_new;
    logic [Q15_W-1:0]  step;
    logic signed [18:0] ng_wide;
    logic [Q15_W-1:0]  gain_ng;
    logic [Q15_W-1:0]  gain_cl;
    logic              out_free;

    assign thr_sat = sat_q15(thr_reg);
    assign flr_sat = sat_q15(flr_reg);
    assign in_len  = (s_axis_tdata[28:16] > LEN_CAP) ? LEN_CAP : s_axis_tdata[28:16];
    assign conf_lt = conf_reg < sm_reg;

    // ---- shared multiply-add: operand select by sequencer step ----
    always_comb
    begin
        mac_a   = '0;
        mac_b   = '0;
        mac_add = '0;
        unique case (state_reg)
            ST_SMOOTH:
            begin
                // |conf - smoothed| * pole, rounded half up
                mac_a   = conf_lt ? $signed({1'b0, sm_reg - conf_reg})
                                  : $signed({1'b0, conf_reg - sm_reg});
                mac_b   = conf_lt ? C_FALL : C_RISE;
                mac_add = ROUND_HALF;
            end
            ST_DES:
            begin
                // interpolation numerator: sm * (1 - floor) + thr/2
                mac_a   = $signed({1'b0, sm_reg});
                mac_b   = UNITY - flr_sat;
                mac_add = {2'b00, thr_sat[Q15_W-1:1]};
            end
            ST_LOOP:
            begin
                // g*c + t*(1-c) == t + (g - t)*c
                mac_a   = $signed({1'b0, gain_reg}) - $signed({1'b0, target_reg});
                mac_b   = coef_reg;
                mac_add = ROUND_HALF;
            end
            default:
            begin
                mac_a   = '0;
                mac_b   = '0;
                mac_add = '0;
            end
        endcase
    end

    cgge_mac u_mac (
        .a      (mac_a),
        .b      (mac_b),
        .addend (mac_add),
        .result (mac_res)
    );

    assign div_needed = (thr_sat > THR_LOW) && (thr_sat < THR_HIGH) && (sm_reg < thr_sat);
    assign div_start  = (state_reg == ST_DES) && div_needed;

    cgge_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mac_res[NUM_W-1:0]),
        .divisor  (thr_sat),
        .done     (div_done),
        .quotient (div_q)
    );

    assign interp_sum = {1'b0, flr_sat} + {1'b0, div_q};
    assign step       = mac_res[31:16];
    assign ng_wide    = $signed({3'b000, target_reg}) + $signed({mac_res[MAC_W-1], mac_res[33:16]});
    assign gain_ng    = ng_wide[Q15_W-1:0];
    assign gain_cl    = (gain_reg < flr_sat) ? flr_sat :
                        (gain_reg > UNITY)   ? UNITY   : gain_reg;
    assign out_free   = !m_valid_reg || m_axis_tready;

    // hold: open target restarts the hold, otherwise a running hold counts down
    always_comb
    begin
        hold_new = hold_reg;
        hold_tgt = des_reg;
        priority if (des_reg >= THR_HIGH)
        begin
            hold_new = hold_samples_reg;
            hold_tgt = des_reg;
        end
        else if (hold_reg != '0)
        begin
            hold_new = (hold_reg > {{(HOLD_W-LEN_W){1'b0}}, len_reg})
                     ? hold_reg - {{(HOLD_W-LEN_W){1'b0}}, len_reg} : '0;
            hold_tgt = UNITY;
        end
        else
        begin
            hold_new = hold_reg;
            hold_tgt = des_reg;
        end
    end

    // ---- sequencer ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            thr_reg          <= '0;
            flr_reg          <= '0;
            atk_reg          <= '0;
            rel_reg          <= '0;
            hold_samples_reg <= '0;
            sm_reg           <= '0;
            gain_reg         <= UNITY;
            hold_reg         <= '0;
            conf_reg         <= '0;
            len_reg          <= '0;
            des_reg          <= '0;
            target_reg       <= '0;
            coef_reg         <= '0;
            gating_reg       <= 1'b0;
            cnt_reg          <= '0;
            m_valid_reg      <= 1'b0;
            m_gain_reg       <= '0;
            m_gating_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_THRESHOLD: thr_reg          <= cfg_data[Q15_W-1:0];
                    CFG_FLOOR:     flr_reg          <= cfg_data[Q15_W-1:0];
                    CFG_ATTACK:    atk_reg          <= cfg_data[Q15_W-1:0];
                    CFG_RELEASE:   rel_reg          <= cfg_data[Q15_W-1:0];
                    CFG_HOLD:      hold_samples_reg <= cfg_data;
                    default:       ;
                endcase
            end

            // ST_DONE reloads the output register itself when it is free
            if (m_axis_tready && (state_reg != ST_DONE))
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        conf_reg  <= sat_q15(s_axis_tdata[15:0]);
                        len_reg   <= in_len;
                        state_reg <= ST_SMOOTH;
                    end
                end
                ST_SMOOTH:
                begin
                    sm_reg    <= conf_lt ? sm_reg - step : sm_reg + step;
                    state_reg <= ST_DES;
                end
                ST_DES:
                begin
                    priority if (thr_sat <= THR_LOW)
                        des_reg <= UNITY;
                    else if (thr_sat >= THR_HIGH)
                        des_reg <= (sm_reg >= THR_HIGH) ? UNITY : flr_sat;
                    else if (sm_reg >= thr_sat)
                        des_reg <= UNITY;
                    else
                        des_reg <= des_reg;
                    state_reg <= div_needed ? ST_DIV : ST_HOLD;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        des_reg   <= (interp_sum > {1'b0, UNITY}) ? UNITY
                                                                  : interp_sum[Q15_W-1:0];
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    hold_reg   <= hold_new;
                    target_reg <= hold_tgt;
                    gating_reg <= hold_tgt < THR_HIGH;
                    coef_reg   <= (hold_tgt < gain_reg) ? atk_reg : rel_reg;
                    cnt_reg    <= '0;
                    state_reg  <= ST_LOOP;
                end
                ST_LOOP:
                begin
                    // stop at block end or once the filter has settled
                    if ((cnt_reg == len_reg) || (gain_ng == gain_reg))
                        state_reg <= ST_DONE;
                    else
                    begin
                        gain_reg <= gain_ng;
                        cnt_reg  <= cnt_reg + 1'b1;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        gain_reg     <= gain_cl;
                        m_gain_reg   <= gain_cl;
                        m_gating_reg <= gating_reg;
                        m_valid_reg  <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_gain_reg;
    assign m_axis_tuser  = m_gating_reg;

    // ---- checks ----
    a_gain_unity: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata <= UNITY))
        else $error("output gain above unity");

    a_sm_range: assert property (@(posedge clk) disable iff (!rst_n)
        sm_reg <= UNITY)
        else $error("smoothed confidence out of range");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (!s_axis_tready && state_reg == ST_SMOOTH))
        else $error("input taken without starting a block");

    a_loop_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOP) |-> (cnt_reg <= len_reg))
        else $error("filter loop ran past block length");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> m_axis_tvalid)
        else $error("finished block not presented");

endmodule

`default_nettype wire
